// ----- rtl/dpos_pkg.sv -----
// ----------------------------------------------------------------------------
// dpos_pkg
// Shared types and constants for the depth pixel to float meters converter.
// ----------------------------------------------------------------------------
package dpos_pkg;

    localparam int APB_AW = 3;

    localparam logic REG_OFFSET = 1'b0;
    localparam logic REG_SCALE  = 1'b1;

    localparam logic [15:0] OFFSET_RESET = 16'h0000;
    localparam logic [23:0] SCALE_ONE    = 24'h010000;
    localparam logic [15:0] MARK_VALUE   = 16'h07FF;
    localparam logic [31:0] QNAN_BITS    = 32'h7FC00000;

    // Normalized mantissa threshold at or above which one bit less of shift is needed.
    localparam logic [15:0] NORM_LIMIT = 16'd64000;
    // floor(2^34 / 1000), reciprocal used for the divide by 1000.
    localparam logic [24:0] RECIP_1000 = 25'd17179869;
    localparam logic [9:0]  MM_PER_M   = 10'd1000;
    localparam logic [9:0]  HALF_MM    = 10'd500;
    // Exponent field base: 149 - 15.
    localparam logic [7:0]  EXP_BASE   = 8'd134;

    typedef struct packed {
        logic signed [15:0] offset;
        logic [23:0]        scale;
    } cfg_t;

    typedef struct packed {
        logic [15:0] value;
        logic        invalid;
        logic        frame_end;
    } pix_t;

endpackage

// ----- rtl/dpos_cfg.sv -----
// ----------------------------------------------------------------------------
// dpos_cfg
// APB register file holding the depth offset and the Q8.16 scale.
// ----------------------------------------------------------------------------
module dpos_cfg
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dpos_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output dpos_pkg::cfg_t              cfg
);

    logic [15:0] offset_reg;
    logic [23:0] scale_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= dpos_pkg::OFFSET_RESET;
            scale_reg  <= dpos_pkg::SCALE_ONE;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                dpos_pkg::REG_OFFSET: offset_reg <= pwdata[15:0];
                dpos_pkg::REG_SCALE:  scale_reg  <= pwdata[23:0];
                default:              offset_reg <= offset_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            dpos_pkg::REG_OFFSET: prdata = {16'h0000, offset_reg};
            dpos_pkg::REG_SCALE:  prdata = {8'h00, scale_reg};
            default:              prdata = 32'h0000_0000;
        endcase
    end

    assign cfg.offset = offset_reg;
    assign cfg.scale  = scale_reg;

endmodule

// ----- rtl/dpos_scale.sv -----
// ----------------------------------------------------------------------------
// dpos_scale
// Two stages: offset add, then Q8.16 scale with saturation and the
// invalid check.
// ----------------------------------------------------------------------------
module dpos_scale
(
    input  logic           clk,
    input  logic           rst_n,
    input  dpos_pkg::cfg_t cfg,
    input  logic           in_vld,
    output logic           in_rdy,
    input  logic [15:0]    raw_depth,
    input  logic           frame_end_in,
    output logic           out_vld,
    input  logic           out_rdy,
    output dpos_pkg::pix_t out_pix
);

    logic        a_vld_reg;
    logic [15:0] a_value_reg;
    logic [15:0] a_value_next;
    logic        a_apply_reg;
    logic        a_apply_next;
    logic        a_fe_reg;
    logic        b_vld_reg;
    dpos_pkg::pix_t b_pix_reg;
    dpos_pkg::pix_t b_pix_next;
    logic        a_adv;
    logic        b_adv;
    logic [39:0] product;
    logic [15:0] scaled;

    assign b_adv  = !b_vld_reg || out_rdy;
    assign a_adv  = !a_vld_reg || b_adv;
    assign in_rdy = a_adv;

    always_comb
    begin
        // A zero sample stays zero; otherwise add the offset with 16-bit wrap.
        if (raw_depth != 16'h0000)
            a_value_next = raw_depth + $unsigned(cfg.offset);
        else
            a_value_next = 16'h0000;
        a_apply_next = (a_value_next != 16'h0000) && (cfg.scale != dpos_pkg::SCALE_ONE);
    end

    always_comb
    begin
        product = 40'(a_value_reg) * 40'(cfg.scale);
        scaled  = (product[39:32] != 8'h00) ? 16'hFFFF : product[31:16];
        b_pix_next.value     = a_apply_reg ? scaled : a_value_reg;
        b_pix_next.invalid   = (b_pix_next.value == 16'h0000) ||
                               (b_pix_next.value == dpos_pkg::MARK_VALUE);
        b_pix_next.frame_end = a_fe_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end
        else
        begin
            if (a_adv)
                a_vld_reg <= in_vld;
            if (b_adv)
                b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_adv && in_vld)
        begin
            a_value_reg <= a_value_next;
            a_apply_reg <= a_apply_next;
            a_fe_reg    <= frame_end_in;
        end
        if (b_adv && a_vld_reg)
            b_pix_reg <= b_pix_next;
    end

    assign out_vld = b_vld_reg;
    assign out_pix = b_pix_reg;

endmodule

// ----- rtl/dpos_to_float.sv -----
// ----------------------------------------------------------------------------
// dpos_to_float
// Four stages turning a millimeter value into float32 meters: normalize,
// reciprocal multiply, remainder correction, then rounding and packing.
// ----------------------------------------------------------------------------
module dpos_to_float
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_vld,
    output logic           in_rdy,
    input  dpos_pkg::pix_t in_pix,
    output logic           out_vld,
    input  logic           out_rdy,
    output logic [31:0]    out_bits,
    output logic           out_invalid,
    output logic           out_fe
);

    typedef struct packed {
        logic [7:0] exp_field;
        logic       half;
        logic       invalid;
        logic       frame_end;
    } side_t;

    // Stage C: normalization.
    logic        c_vld_reg;
    logic [15:0] c_m_reg;
    logic [15:0] c_m_next;
    side_t       c_side_reg;
    side_t       c_side_next;
    logic [3:0]  lead;

    // Stage D: quotient estimate.
    logic        d_vld_reg;
    logic [15:0] d_m_reg;
    logic [24:0] d_q_reg;
    logic [40:0] d_prod;
    side_t       d_side_reg;

    // Stage E: exact quotient and remainder.
    logic        e_vld_reg;
    logic [24:0] e_q_reg;
    logic [24:0] e_q_next;
    logic [9:0]  e_r_reg;
    logic [9:0]  e_r_next;
    logic [34:0] e_r_wide;
    logic [10:0] e_r_raw;
    side_t       e_side_reg;

    // Stage F: rounding and packing.
    logic        f_vld_reg;
    logic [31:0] f_bits_reg;
    logic [31:0] f_bits_next;
    logic        f_inv_reg;
    logic        f_fe_reg;
    logic [23:0] mant;
    logic        round_up;
    logic [24:0] mant_rnd;

    logic        c_adv;
    logic        d_adv;
    logic        e_adv;
    logic        f_adv;

    assign f_adv  = !f_vld_reg || out_rdy;
    assign e_adv  = !e_vld_reg || f_adv;
    assign d_adv  = !d_vld_reg || e_adv;
    assign c_adv  = !c_vld_reg || d_adv;
    assign in_rdy = c_adv;

    always_comb
    begin
        lead = 4'd0;
        for (int i = 0; i < 16; i++)
        begin
            if (in_pix.value[i])
                lead = 4'(i);
        end
        c_m_next = in_pix.value << (4'd15 - lead);
        // With the leading one at bit 15, the quotient needs a shift of 18
        // more bits, or 17 when the mantissa is already at 64000 or above.
        c_side_next.half      = (c_m_next >= dpos_pkg::NORM_LIMIT);
        c_side_next.exp_field = dpos_pkg::EXP_BASE + 8'(lead) - (c_side_next.half ? 8'd17 : 8'd18);
        c_side_next.invalid   = in_pix.invalid;
        c_side_next.frame_end = in_pix.frame_end;
    end

    assign d_prod = 41'(c_m_reg) * 41'(dpos_pkg::RECIP_1000);

    always_comb
    begin
        // The estimate is low by at most one; one compare fixes it.
        e_r_wide = {1'b0, d_m_reg, 18'h00000} - 35'(d_q_reg) * 35'(dpos_pkg::MM_PER_M);
        e_r_raw  = e_r_wide[10:0];
        if (e_r_raw >= 11'(dpos_pkg::MM_PER_M))
        begin
            e_q_next = d_q_reg + 25'd1;
            e_r_next = 10'(e_r_raw - 11'(dpos_pkg::MM_PER_M));
        end
        else
        begin
            e_q_next = d_q_reg;
            e_r_next = e_r_raw[9:0];
        end
    end

    always_comb
    begin
        if (e_side_reg.half)
        begin
            // Halving the quotient: the dropped bit and the remainder decide; an exact tie rounds to even.
            mant     = e_q_reg[24:1];
            round_up = e_q_reg[0] && ((e_r_reg != 10'd0) || e_q_reg[1]);
        end
        else
        begin
            mant     = e_q_reg[23:0];
            round_up = (e_r_reg > dpos_pkg::HALF_MM) ||
                       ((e_r_reg == dpos_pkg::HALF_MM) && e_q_reg[0]);
        end
        mant_rnd = {1'b0, mant} + 25'(round_up);
        // A mantissa that rounds up to 2^24 carries into the exponent.
        if (e_side_reg.invalid)
            f_bits_next = dpos_pkg::QNAN_BITS;
        else
            f_bits_next = {1'b0, e_side_reg.exp_field, 23'h000000} + {7'h00, mant_rnd};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
            e_vld_reg <= 1'b0;
            f_vld_reg <= 1'b0;
        end
        else
        begin
            if (c_adv)
                c_vld_reg <= in_vld;
            if (d_adv)
                d_vld_reg <= c_vld_reg;
            if (e_adv)
                e_vld_reg <= d_vld_reg;
            if (f_adv)
                f_vld_reg <= e_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_adv && in_vld)
        begin
            c_m_reg    <= c_m_next;
            c_side_reg <= c_side_next;
        end
        if (d_adv && c_vld_reg)
        begin
            d_m_reg    <= c_m_reg;
            d_q_reg    <= d_prod[40:16];
            d_side_reg <= c_side_reg;
        end
        if (e_adv && d_vld_reg)
        begin
            e_q_reg    <= e_q_next;
            e_r_reg    <= e_r_next;
            e_side_reg <= d_side_reg;
        end
        if (f_adv && e_vld_reg)
        begin
            f_bits_reg <= f_bits_next;
            f_inv_reg  <= e_side_reg.invalid;
            f_fe_reg   <= e_side_reg.frame_end;
        end
    end

    assign out_vld     = f_vld_reg;
    assign out_bits    = f_bits_reg;
    assign out_invalid = f_inv_reg;
    assign out_fe      = f_fe_reg;

`ifndef SYNTHESIS
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        e_vld_reg |-> (e_r_reg < dpos_pkg::MM_PER_M))
        else $error("remainder not reduced below 1000");

    a_invalid_is_nan: assert property (@(posedge clk) disable iff (!rst_n)
        (f_vld_reg && f_inv_reg) |-> (f_bits_reg == dpos_pkg::QNAN_BITS))
        else $error("invalid pixel without quiet NaN");

    a_exp_range: assert property (@(posedge clk) disable iff (!rst_n)
        (f_vld_reg && !f_inv_reg) |-> (!f_bits_reg[31] &&
            (f_bits_reg[30:23] >= 8'd116) && (f_bits_reg[30:23] <= 8'd133)))
        else $error("valid pixel with exponent out of range");
`endif

endmodule

// ----- rtl/depth_pixel_offset_scale_to_meters.sv -----
// ----------------------------------------------------------------------------
// depth_pixel_offset_scale_to_meters
// Converts millimeter depth pixels to float32 meters after offset and scale.
// ----------------------------------------------------------------------------
// Usage: depth items enter on raw_depth/frame_end_in under in_valid; the
// block holds them off with in_stall. Results leave on depth_meters_bits,
// pixel_invalid and frame_end_out under out_valid, held off by out_stall.
// The offset and Q8.16 scale registers sit on the APB port at byte
// addresses 0 and 4; write them only while no items are in flight.
// Six register stages: offset, scale, normalize, reciprocal multiply,
// remainder correction, round and pack. A result reaches the outputs
// once its item has passed through each stage in that order, and one
// item per cycle is sustained while out_stall stays low; the 16x24 scale
// multiply and the 16x25 reciprocal multiply each fill one stage.
// Reset empties the pipeline and loads offset 0 and scale 1.0. When the
// receiver stalls, the output register holds its item and bubbles ahead
// of it are squeezed out before in_stall rises; nothing is lost.
// ----------------------------------------------------------------------------
module depth_pixel_offset_scale_to_meters
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dpos_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [15:0]                 raw_depth,
    input  logic                        frame_end_in,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [31:0]                 depth_meters_bits,
    output logic                        pixel_invalid,
    output logic                        frame_end_out
);

    dpos_pkg::cfg_t cfg;
    dpos_pkg::pix_t mid_pix;
    logic           mid_vld;
    logic           mid_rdy;
    logic           in_rdy;

    dpos_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dpos_scale u_scale
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .in_vld       (in_valid),
        .in_rdy       (in_rdy),
        .raw_depth    (raw_depth),
        .frame_end_in (frame_end_in),
        .out_vld      (mid_vld),
        .out_rdy      (mid_rdy),
        .out_pix      (mid_pix)
    );

    dpos_to_float u_to_float
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_vld      (mid_vld),
        .in_rdy      (mid_rdy),
        .in_pix      (mid_pix),
        .out_vld     (out_valid),
        .out_rdy     (!out_stall),
        .out_bits    (depth_meters_bits),
        .out_invalid (pixel_invalid),
        .out_fe      (frame_end_out)
    );

    assign in_stall = !in_rdy;

endmodule
